FILE: sv/quaternion_to_euler_angles_core_assert.svh
// Assertion macros shared by the quaternion-to-Euler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

// Same-cycle implication check.
`define Q2E_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define Q2E_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/q2e_pkg.sv
// Shared types and constants of the quaternion-to-Euler core.
// No dependencies; used by the cell modules and the top level.
package q2e_pkg;

   localparam int CW         = 38;   // CORDIC x/y width
   localparam int ZW         = 28;   // angle accumulator width, degrees * 2^16
   localparam int NW         = 63;   // square root radicand width
   localparam int SQRT_STEPS = 32;
   localparam int SW         = 34;   // width of the atan2 arguments
   localparam int MAX_TABLE  = 24;
   localparam int PITCH_LIM  = 11520;
   localparam int ANGLE_LIM  = 23040;
   localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * 65536);

   localparam logic signed [ZW-1:0] ATAN_DEG16 [MAX_TABLE] = '{
      ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379),
      ZW'(117304), ZW'(58666), ZW'(29335), ZW'(14668), ZW'(7334), ZW'(3667),
      ZW'(1833), ZW'(917), ZW'(458), ZW'(229), ZW'(115), ZW'(57), ZW'(29),
      ZW'(14), ZW'(7), ZW'(4), ZW'(2), ZW'(1), ZW'(0)
   };

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_vec_type;

   typedef struct packed {
      logic [NW-1:0] n;
      logic [NW-1:0] r;
   } sqrt_lane_type;

   typedef struct packed {
      logic signed [SW-1:0] roll_y;
      logic signed [SW-1:0] roll_x;
      logic signed [SW-1:0] yaw_y;
      logic signed [SW-1:0] yaw_x;
      logic signed [31:0]   asin_arg;
      logic                 clamped;
   } side_type;

endpackage

FILE: sv/quaternion_to_euler_angles_core.sv
// Top level of the quaternion to ZYX Euler angle core.
// Depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_cell and the assertion header.
//
//   Channel  Direction  Contents
//   req_     in         quat_w, quat_x, quat_y, quat_z (tdata)
//   rsp_     out        pitch_angle, roll_angle, yaw_angle (tdata), pitch_clamped (tuser)
//
// One transaction is accepted every cycle while rsp_ is not stalled; the pipeline
// holds the products, sums, the arcsine square, 32 square-root cells, the quadrant
// turn, one cell per CORDIC iteration and the output register.
// Reset is synchronous and clears only the valid bits of the pipeline.
// A stall on rsp_ freezes the whole pipeline at once, so req_tready falls in
// the same cycle that the output register holds an untaken result.
`include "quaternion_to_euler_angles_core_assert.svh"

module quaternion_to_euler_angles_core #(
   parameter int CORDIC_STAGES = 16,
   parameter int QUAT_WIDTH    = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // quat_w, quat_x, quat_y, quat_z from the lowest bit up, zero padded
   input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pitch_angle (15), roll_angle (16), yaw_angle (16), one zero pad bit
   output logic [47:0] rsp_tdata,
   // pitch_clamped
   output logic rsp_tuser
);
   localparam int K   = 2 * (QUAT_WIDTH - 1) - 30;
   localparam int SHR = (K >= 0) ? K : 0;
   localparam int SHL = (K < 0) ? -K : 0;
   localparam int CW  = q2e_pkg::CW;
   localparam int ZW  = q2e_pkg::ZW;
   localparam int SW  = q2e_pkg::SW;
   localparam logic signed [SW-1:0] ONE = SW'(64'sd1 << 30);

   // Product of two components brought to Q2.30.
   function automatic logic signed [31:0] mul_q30(input logic signed [QUAT_WIDTH-1:0] a,
                                                  input logic signed [QUAT_WIDTH-1:0] b);
      logic signed [2*QUAT_WIDTH-1:0] p;
      logic signed [63:0]             pe;
      p  = a * b;
      pe = 64'(p);
      pe = (pe <<< SHL) >>> SHR;
      return pe[31:0];
   endfunction

   // Quadrant turn ahead of the CORDIC so that x starts non-negative.
   function automatic q2e_pkg::cordic_vec_type prerot(input logic signed [CW-1:0] y,
                                                      input logic signed [CW-1:0] x);
      q2e_pkg::cordic_vec_type v;
      v.x    = x;
      v.y    = y;
      v.z    = '0;
      v.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         if (y >= 0) begin
            v.x = y;
            v.y = -x;
            v.z = q2e_pkg::QUARTER_TURN;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -q2e_pkg::QUARTER_TURN;
         end
      end
      return v;
   endfunction

   // Round from 2^-16 to 2^-7 degree, then saturate.
   function automatic logic signed [15:0] round_sat(input logic signed [ZW:0] v,
                                                    input int lim);
      logic signed [ZW:0] t;
      logic signed [ZW:0] l;
      t = (v + (ZW+1)'(256)) >>> 9;
      l = (ZW+1)'(lim);
      if (t > l) t = l;
      if (t < -l) t = -l;
      return t[15:0];
   endfunction

   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage A: the ten component products.
   logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;
   assign qw = req_tdata[QUAT_WIDTH-1:0];
   assign qx = req_tdata[2*QUAT_WIDTH-1:QUAT_WIDTH];
   assign qy = req_tdata[3*QUAT_WIDTH-1:2*QUAT_WIDTH];
   assign qz = req_tdata[4*QUAT_WIDTH-1:3*QUAT_WIDTH];

   logic               mvalid_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xz_ff, wy_ff, wx_ff, yz_ff, xy_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= 1'b0;
      end else if (adv) begin
         mvalid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ww_ff <= mul_q30(qw, qw);
         xx_ff <= mul_q30(qx, qx);
         yy_ff <= mul_q30(qy, qy);
         zz_ff <= mul_q30(qz, qz);
         xz_ff <= mul_q30(qx, qz);
         wy_ff <= mul_q30(qw, qy);
         wx_ff <= mul_q30(qw, qx);
         yz_ff <= mul_q30(qy, qz);
         xy_ff <= mul_q30(qx, qy);
         wz_ff <= mul_q30(qw, qz);
      end
   end

   // Stage B: sums, the arcsine argument and its clamp.
   logic                 bvalid_ff;
   q2e_pkg::side_type    bside_ff, bside_in;
   logic signed [SW-1:0] a_raw;

   always_comb begin
      a_raw              = (SW'(xz_ff) - SW'(wy_ff)) <<< 1;
      bside_in.roll_y    = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
      bside_in.roll_x    = SW'(ww_ff) - SW'(xx_ff) - SW'(yy_ff) + SW'(zz_ff);
      bside_in.yaw_y     = (SW'(xy_ff) + SW'(wz_ff)) <<< 1;
      bside_in.yaw_x     = SW'(ww_ff) + SW'(xx_ff) - SW'(yy_ff) - SW'(zz_ff);
      bside_in.clamped   = (a_raw > ONE) || (a_raw < -ONE);
      if (a_raw > ONE) begin
         bside_in.asin_arg = ONE[31:0];
      end else if (a_raw < -ONE) begin
         bside_in.asin_arg = -ONE[31:0];
      end else begin
         bside_in.asin_arg = a_raw[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= 1'b0;
      end else if (adv) begin
         bvalid_ff <= mvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bside_ff <= bside_in;
      end
   end

   // Stage C: radicand 2^60 - a^2.
   logic                   cvalid_ff;
   q2e_pkg::side_type      cside_ff;
   logic [q2e_pkg::NW-1:0] radicand_ff;
   logic signed [63:0]     asq;

   assign asq = bside_ff.asin_arg * bside_ff.asin_arg;

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= 1'b0;
      end else if (adv) begin
         cvalid_ff <= bvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cside_ff    <= bside_ff;
         radicand_ff <= q2e_pkg::NW'(64'd1 << 60) - asq[q2e_pkg::NW-1:0];
      end
   end

   // Square root chain; the other operands ride along.
   logic                   sq_valid [q2e_pkg::SQRT_STEPS+1];
   q2e_pkg::sqrt_lane_type sq_lane  [q2e_pkg::SQRT_STEPS+1];
   q2e_pkg::side_type      sq_side  [q2e_pkg::SQRT_STEPS+1];

   assign sq_valid[0]  = cvalid_ff;
   assign sq_lane[0].n = radicand_ff;
   assign sq_lane[0].r = '0;
   assign sq_side[0]   = cside_ff;

   for (genvar s = 0; s < q2e_pkg::SQRT_STEPS; s++) begin : g_sqrt
      q2e_sqrt_cell #(.STEP(s)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (sq_valid[s]),
         .in_lane  (sq_lane[s]),
         .in_side  (sq_side[s]),
         .out_valid(sq_valid[s+1]),
         .out_lane (sq_lane[s+1]),
         .out_side (sq_side[s+1])
      );
   end

   // Quadrant turn stage feeding the CORDIC chain: lane 0 pitch, 1 roll, 2 yaw.
   q2e_pkg::side_type sq_out;
   assign sq_out = sq_side[q2e_pkg::SQRT_STEPS];

   logic                          cd_valid [CORDIC_STAGES+1];
   logic                          cd_tag   [CORDIC_STAGES+1];
   q2e_pkg::cordic_vec_type [2:0] cd_vec   [CORDIC_STAGES+1];
   logic                          pvalid_ff;
   logic                          ptag_ff;
   q2e_pkg::cordic_vec_type [2:0] pvec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else if (adv) begin
         pvalid_ff <= sq_valid[q2e_pkg::SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ptag_ff    <= sq_out.clamped;
         pvec_ff[0] <= prerot(CW'(sq_out.asin_arg),
                              CW'(signed'({1'b0, sq_lane[q2e_pkg::SQRT_STEPS].r})));
         pvec_ff[1] <= prerot(CW'(sq_out.roll_y), CW'(sq_out.roll_x));
         pvec_ff[2] <= prerot(CW'(sq_out.yaw_y), CW'(sq_out.yaw_x));
      end
   end

   assign cd_valid[0] = pvalid_ff;
   assign cd_tag[0]   = ptag_ff;
   assign cd_vec[0]   = pvec_ff;

   for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
      q2e_cordic_cell #(.STAGE(c)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (cd_valid[c]),
         .in_tag   (cd_tag[c]),
         .in_vec   (cd_vec[c]),
         .out_valid(cd_valid[c+1]),
         .out_tag  (cd_tag[c+1]),
         .out_vec  (cd_vec[c+1])
      );
   end

   // Output register: rounding, saturation and the zero-vector case.
   q2e_pkg::cordic_vec_type [2:0] fin;
   logic signed [15:0]            pitch_in, roll_in, yaw_in;
   logic signed [14:0]            pitch_ff;
   logic signed [15:0]            roll_ff, yaw_ff;
   logic                          clamp_ff;

   assign fin = cd_vec[CORDIC_STAGES];

   always_comb begin
      pitch_in = round_sat(-(ZW+1)'(fin[0].z), q2e_pkg::PITCH_LIM);
      roll_in  = round_sat((ZW+1)'(fin[1].z), q2e_pkg::ANGLE_LIM);
      yaw_in   = round_sat((ZW+1)'(fin[2].z), q2e_pkg::ANGLE_LIM);
      if (fin[0].zero) pitch_in = '0;
      if (fin[1].zero) roll_in = '0;
      if (fin[2].zero) yaw_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cd_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pitch_ff <= pitch_in[14:0];
         roll_ff  <= roll_in;
         yaw_ff   <= yaw_in;
         clamp_ff <= cd_tag[CORDIC_STAGES];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, yaw_ff, roll_ff, pitch_ff};
   assign rsp_tuser  = clamp_ff;

   // A clamped arcsine argument always lands on a pole.
   `Q2E_ASSERT_IMP(a_clamp_pole, clock, reset, rsp_valid_ff && clamp_ff,
      (pitch_ff == 15'sd11520) || (pitch_ff == -15'sd11520), "clamp without pole pitch")
   `Q2E_ASSERT_IMP(a_clamp_arg, clock, reset, bvalid_ff && bside_ff.clamped,
      (bside_ff.asin_arg == ONE[31:0]) || (bside_ff.asin_arg == -ONE[31:0]),
      "clamped argument not at unit magnitude")
   `Q2E_ASSERT_IMP(a_angle_range, clock, reset, rsp_valid_ff,
      (roll_ff <= 16'sd23040) && (roll_ff >= -16'sd23040) &&
      (yaw_ff <= 16'sd23040) && (yaw_ff >= -16'sd23040), "angle out of range")
   `Q2E_ASSERT_NXT(a_stage_move, clock, reset, mvalid_ff && adv, bvalid_ff,
      "transaction lost between product and sum stages")
endmodule

FILE: sv/q2e_sqrt_cell.sv
// One step of the pipelined integer square root, one result bit per cell.
// Depends on q2e_pkg.
module q2e_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  q2e_pkg::sqrt_lane_type  in_lane,
   input  q2e_pkg::side_type       in_side,
   output logic                    out_valid,
   output q2e_pkg::sqrt_lane_type  out_lane,
   output q2e_pkg::side_type       out_side
);
   localparam logic [q2e_pkg::NW-1:0] BIT = q2e_pkg::NW'(1) << (62 - 2 * STEP);

   logic                   valid_ff;
   q2e_pkg::sqrt_lane_type lane_ff, lane_in;
   q2e_pkg::side_type      side_ff;
   logic [q2e_pkg::NW-1:0] trial;

   always_comb begin
      trial   = in_lane.r + BIT;
      lane_in = in_lane;
      if (in_lane.n >= trial) begin
         lane_in.n = in_lane.n - trial;
         lane_in.r = (in_lane.r >> 1) + BIT;
      end else begin
         lane_in.r = in_lane.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_side  = side_ff;
endmodule

FILE: sv/q2e_cordic_cell.sv
// One vectoring CORDIC iteration for the pitch, roll and yaw lanes.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic                         in_tag,
   input  q2e_pkg::cordic_vec_type [2:0] in_vec,
   output logic                         out_valid,
   output logic                         out_tag,
   output q2e_pkg::cordic_vec_type [2:0] out_vec
);
   logic                          valid_ff;
   logic                          tag_ff;
   q2e_pkg::cordic_vec_type [2:0] vec_ff, vec_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vec_in[k] = in_vec[k];
         if (in_vec[k].y > 0) begin
            vec_in[k].x = in_vec[k].x + (in_vec[k].y >>> STAGE);
            vec_in[k].y = in_vec[k].y - (in_vec[k].x >>> STAGE);
            vec_in[k].z = in_vec[k].z + q2e_pkg::ATAN_DEG16[STAGE];
         end else begin
            vec_in[k].x = in_vec[k].x - (in_vec[k].y >>> STAGE);
            vec_in[k].y = in_vec[k].y + (in_vec[k].x >>> STAGE);
            vec_in[k].z = in_vec[k].z - q2e_pkg::ATAN_DEG16[STAGE];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff <= vec_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_vec   = vec_ff;
endmodule
